@@ rtl/lfu_pkg.sv @@
// Shared types and constants for the LFU cache: request and response
// payloads, the broadcast command that the controller sends down the cell row.
// No dependencies.
package lfu_pkg;

  localparam int KEY_W  = 32;
  localparam int DATA_W = 32;
  localparam int CAP_W  = 5;

  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  typedef struct packed {
    logic                     kind;
    logic [KEY_W-1:0]         key;
    logic signed [DATA_W-1:0] value;
  } lfu_req_t;

  typedef struct packed {
    logic                     hit;
    logic signed [DATA_W-1:0] read_value;
  } lfu_rsp_t;

  localparam logic KIND_GET = 1'b0;
  localparam logic KIND_PUT = 1'b1;

  typedef enum logic [1:0] {
    CMD_NONE   = 2'd0,
    CMD_TOUCH  = 2'd1,
    CMD_EVICT  = 2'd2,
    CMD_INSERT = 2'd3
  } lfu_op_t;

  typedef struct packed {
    lfu_op_t                  op;
    logic                     wr_data;
    logic [KEY_W-1:0]         key;
    logic signed [DATA_W-1:0] data;
  } lfu_cmd_t;

endpackage

@@ rtl/lfu_cell.sv @@
// One cache slot: valid, key, data, use count and recency rank, plus one
// stage of the victim / free-slot sweep that runs along the cell row.
// Depends on lfu_pkg.
module lfu_cell import lfu_pkg::*; #(
  parameter int IDX_W      = 4,
  parameter int COUNT_BITS = 16,
  parameter int CELL_IDX   = 0
) (
  input  logic                     clk,
  input  logic                     rst,
  input  lfu_cmd_t                 cmd,
  input  logic [IDX_W-1:0]         cmd_idx,
  input  logic [IDX_W-1:0]         cmd_rank,
  input  logic [KEY_W-1:0]         lookup_key,
  output logic                     match,
  output logic                     valid_out,
  output logic signed [DATA_W-1:0] data_out,
  output logic [IDX_W-1:0]         rank_out,
  input  logic                     prev_vic_found,
  input  logic [IDX_W-1:0]         prev_vic_idx,
  input  logic [COUNT_BITS-1:0]    prev_vic_count,
  input  logic [IDX_W-1:0]         prev_vic_rank,
  input  logic                     prev_free_found,
  input  logic [IDX_W-1:0]         prev_free_idx,
  output logic                     next_vic_found,
  output logic [IDX_W-1:0]         next_vic_idx,
  output logic [COUNT_BITS-1:0]    next_vic_count,
  output logic [IDX_W-1:0]         next_vic_rank,
  output logic                     next_free_found,
  output logic [IDX_W-1:0]         next_free_idx
);

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

  logic                     valid;
  logic [KEY_W-1:0]         key;
  logic signed [DATA_W-1:0] data;
  logic [COUNT_BITS-1:0]    count;
  logic [IDX_W-1:0]         rank;
  logic                     is_target;
  logic                     own_better;

  assign is_target = (cmd_idx == MY_IDX);
  assign match     = valid && (key == lookup_key);
  assign valid_out = valid;
  assign data_out  = data;
  assign rank_out  = rank;

  // Lower count wins; on equal counts the older (higher rank) entry wins.
  assign own_better = !prev_vic_found || (count < prev_vic_count) ||
                      ((count == prev_vic_count) && (rank > prev_vic_rank));

  always_ff @(posedge clk) begin
    if (rst) begin
      valid           <= 1'b0;
      next_vic_found  <= 1'b0;
      next_free_found <= 1'b0;
    end else begin
      // Sweep stage: pass the best candidate so far, or take over.
      if (valid && own_better) begin
        next_vic_found <= 1'b1;
        next_vic_idx   <= MY_IDX;
        next_vic_count <= count;
        next_vic_rank  <= rank;
      end else begin
        next_vic_found <= prev_vic_found;
        next_vic_idx   <= prev_vic_idx;
        next_vic_count <= prev_vic_count;
        next_vic_rank  <= prev_vic_rank;
      end
      if (!valid && !prev_free_found) begin
        next_free_found <= 1'b1;
        next_free_idx   <= MY_IDX;
      end else begin
        next_free_found <= prev_free_found;
        next_free_idx   <= prev_free_idx;
      end

      unique case (cmd.op)
        CMD_TOUCH: begin
          if (valid && (rank < cmd_rank)) rank <= rank + IDX_W'(1);
          if (is_target) begin
            rank <= '0;
            if (count != '1) count <= count + COUNT_BITS'(1);
            if (cmd.wr_data) data <= cmd.data;
          end
        end
        CMD_EVICT: begin
          if (valid && (rank > cmd_rank)) rank <= rank - IDX_W'(1);
          if (is_target) valid <= 1'b0;
        end
        CMD_INSERT: begin
          if (valid) rank <= rank + IDX_W'(1);
          if (is_target) begin
            valid <= 1'b1;
            key   <= cmd.key;
            data  <= cmd.data;
            count <= COUNT_BITS'(1);
            rank  <= '0;
          end
        end
        CMD_NONE: begin
        end
      endcase
    end
  end

endmodule

@@ rtl/lfu_cache_unit.sv @@
// Top level of the LFU cache: controller, request/response registers and
// the row of lfu_cell slots. Depends on lfu_pkg and lfu_cell.
//
//  channel | signals                    | direction | transaction
//  --------+----------------------------+-----------+------------------------------
//  req     | req_valid, req_ready, req  | in        | one get or put request
//  rsp     | rsp_valid, rsp_ready, rsp  | out       | one result per get, none per put
//  cfg     | cfg_valid, cfg_ready, cfg_data | in    | write of capacity
//
// Steps: a get or a put to a present key passes accept, key compare, and
// decide and update. A put of a new key then runs passes of the victim /
// free-slot sweep, one pass per eviction plus one for the insert; the sweep
// walks the cell row one cell per cycle. With capacity 0 a put is dropped.
// Reset clears all valid bits and occupancy at once and sets capacity to 16.
// A get whose result register is still full holds in the decide step until
// the earlier transaction is taken; cfg is always ready.
module lfu_cache_unit import lfu_pkg::*; #(
  parameter int ENTRIES    = 16,
  parameter int COUNT_BITS = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             req_valid,
  output logic             req_ready,
  input  lfu_req_t         req,
  output logic             rsp_valid,
  input  logic             rsp_ready,
  output lfu_rsp_t         rsp,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [CAP_W-1:0] cfg_data
);

  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int OCC_W = $clog2(ENTRIES + 1);
  localparam int CMP_W = (OCC_W > CAP_W) ? OCC_W : CAP_W;

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_LOOKUP = 5'b00010,
    ST_DECIDE = 5'b00100,
    ST_SWEEP  = 5'b01000,
    ST_PICK   = 5'b10000
  } state_t;

  state_t state, state_next;

  logic [CAP_W-1:0]  capacity;
  logic [OCC_W-1:0]  occupancy;
  logic [IDX_W-1:0]  sweep_cnt;
  lfu_req_t          req_q;

  // Registered lookup result.
  logic                     hit_q;
  logic [IDX_W-1:0]         hit_idx;
  logic [IDX_W-1:0]         hit_rank;
  logic signed [DATA_W-1:0] hit_data;

  // Combinational lookup select over the row.
  logic                     hit_any;
  logic [IDX_W-1:0]         sel_idx;
  logic [IDX_W-1:0]         sel_rank;
  logic signed [DATA_W-1:0] sel_data;

  logic [CMP_W-1:0] cap_ext;
  logic [CMP_W-1:0] cap_eff;
  logic [CMP_W-1:0] occ_ext;
  logic             need_evict;
  logic             rsp_free;
  logic             rsp_load;

  lfu_cmd_t         cmd;
  logic [IDX_W-1:0] cmd_idx;
  logic [IDX_W-1:0] cmd_rank;

  logic                     match_vec [ENTRIES];
  logic                     valid_vec [ENTRIES];
  logic signed [DATA_W-1:0] data_vec  [ENTRIES];
  logic [IDX_W-1:0]         rank_vec  [ENTRIES];
  logic [ENTRIES-1:0]       match_bits;
  logic [ENTRIES-1:0]       valid_bits;

  // Sweep chain between cells; link 0 feeds an empty candidate.
  logic                  vic_found  [ENTRIES+1];
  logic [IDX_W-1:0]      vic_idx    [ENTRIES+1];
  logic [COUNT_BITS-1:0] vic_count  [ENTRIES+1];
  logic [IDX_W-1:0]      vic_rank   [ENTRIES+1];
  logic                  free_found [ENTRIES+1];
  logic [IDX_W-1:0]      free_idx   [ENTRIES+1];

  assign vic_found[0]  = 1'b0;
  assign vic_idx[0]    = '0;
  assign vic_count[0]  = '0;
  assign vic_rank[0]   = '0;
  assign free_found[0] = 1'b0;
  assign free_idx[0]   = '0;

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    lfu_cell #(
      .IDX_W      (IDX_W),
      .COUNT_BITS (COUNT_BITS),
      .CELL_IDX   (i)
    ) u_cell (
      .clk             (clk),
      .rst             (rst),
      .cmd             (cmd),
      .cmd_idx         (cmd_idx),
      .cmd_rank        (cmd_rank),
      .lookup_key      (req_q.key),
      .match           (match_vec[i]),
      .valid_out       (valid_vec[i]),
      .data_out        (data_vec[i]),
      .rank_out        (rank_vec[i]),
      .prev_vic_found  (vic_found[i]),
      .prev_vic_idx    (vic_idx[i]),
      .prev_vic_count  (vic_count[i]),
      .prev_vic_rank   (vic_rank[i]),
      .prev_free_found (free_found[i]),
      .prev_free_idx   (free_idx[i]),
      .next_vic_found  (vic_found[i+1]),
      .next_vic_idx    (vic_idx[i+1]),
      .next_vic_count  (vic_count[i+1]),
      .next_vic_rank   (vic_rank[i+1]),
      .next_free_found (free_found[i+1]),
      .next_free_idx   (free_idx[i+1])
    );
    assign match_bits[i] = match_vec[i];
    assign valid_bits[i] = valid_vec[i];
  end

  // Keys are unique among valid slots, so at most one cell matches:
  // an OR of the masked fields selects it.
  always_comb begin
    hit_any  = 1'b0;
    sel_idx  = '0;
    sel_rank = '0;
    sel_data = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (match_vec[i]) begin
        hit_any  = 1'b1;
        sel_idx  = sel_idx | IDX_W'(i);
        sel_rank = sel_rank | rank_vec[i];
        sel_data = sel_data | data_vec[i];
      end
    end
  end

  // Capacity above the slot count saturates.
  assign cap_ext    = CMP_W'(capacity);
  assign cap_eff    = (cap_ext > CMP_W'(ENTRIES)) ? CMP_W'(ENTRIES) : cap_ext;
  assign occ_ext    = CMP_W'(occupancy);
  assign need_evict = (occ_ext >= cap_eff) && (occupancy != '0);

  assign rsp_free  = !rsp_valid || rsp_ready;
  assign req_ready = (state == ST_IDLE);
  assign cfg_ready = 1'b1;

  // Controller: pick the next state and the command broadcast to the row.
  always_comb begin
    state_next  = state;
    cmd.op      = CMD_NONE;
    cmd.wr_data = 1'b0;
    cmd.key     = req_q.key;
    cmd.data    = req_q.value;
    cmd_idx     = hit_idx;
    cmd_rank    = hit_rank;
    rsp_load    = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (req_valid) state_next = ST_LOOKUP;
      end
      ST_LOOKUP: begin
        state_next = ST_DECIDE;
      end
      ST_DECIDE: begin
        if (req_q.kind == KIND_GET) begin
          // Hold until the result register can take this transaction.
          if (rsp_free) begin
            rsp_load   = 1'b1;
            state_next = ST_IDLE;
            if (hit_q) cmd.op = CMD_TOUCH;
          end
        end else if (cap_eff == '0) begin
          state_next = ST_IDLE;
        end else if (hit_q) begin
          cmd.op      = CMD_TOUCH;
          cmd.wr_data = 1'b1;
          state_next  = ST_IDLE;
        end else begin
          state_next = ST_SWEEP;
        end
      end
      ST_SWEEP: begin
        if (sweep_cnt == IDX_W'(ENTRIES - 1)) state_next = ST_PICK;
      end
      ST_PICK: begin
        // The last link now holds the settled victim and first free slot.
        if (need_evict) begin
          cmd.op     = CMD_EVICT;
          cmd_idx    = vic_idx[ENTRIES];
          cmd_rank   = vic_rank[ENTRIES];
          state_next = ST_SWEEP;
        end else begin
          if (free_found[ENTRIES]) cmd.op = CMD_INSERT;
          cmd_idx    = free_idx[ENTRIES];
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      capacity  <= CAP_RESET;
      occupancy <= '0;
      rsp_valid <= 1'b0;
      sweep_cnt <= '0;
    end else begin
      state <= state_next;
      if (cfg_valid) capacity <= cfg_data;

      // Advance the sweep wait; restart it whenever the sweep is entered.
      if (state == ST_SWEEP) sweep_cnt <= sweep_cnt + IDX_W'(1);
      else                   sweep_cnt <= '0;

      if (cmd.op == CMD_EVICT)  occupancy <= occupancy - OCC_W'(1);
      if (cmd.op == CMD_INSERT) occupancy <= occupancy + OCC_W'(1);

      if (rsp_load)                    rsp_valid <= 1'b1;
      else if (rsp_valid && rsp_ready) rsp_valid <= 1'b0;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (req_valid && req_ready) req_q <= req;
    if (state == ST_LOOKUP) begin
      hit_q    <= hit_any;
      hit_idx  <= sel_idx;
      hit_rank <= sel_rank;
      hit_data <= sel_data;
    end
    if (rsp_load) begin
      rsp.hit        <= hit_q;
      rsp.read_value <= hit_q ? hit_data : '0;
    end
  end

  // Occupancy tracks the number of valid slots.
  a_occ_count: assert property (@(posedge clk) disable iff (rst)
    occupancy == OCC_W'($countones(valid_bits)))
    else $error("occupancy differs from the number of valid slots");

  // A key is never held in two slots.
  a_key_unique: assert property (@(posedge clk) disable iff (rst)
    $onehot0(match_bits))
    else $error("key matches more than one slot");

  // Once no eviction is due, the sweep has found a free slot for the insert.
  a_free_slot: assert property (@(posedge clk) disable iff (rst)
    (state == ST_PICK && !need_evict) |-> free_found[ENTRIES])
    else $error("insert with no free slot");

  // An eviction always has a settled victim to drop.
  a_victim_found: assert property (@(posedge clk) disable iff (rst)
    (state == ST_PICK && need_evict) |-> vic_found[ENTRIES])
    else $error("eviction with no victim");

  // A get result is loaded only from the decide step.
  a_rsp_source: assert property (@(posedge clk) disable iff (rst)
    (!rsp_valid ##1 rsp_valid) |-> $past(state == ST_DECIDE && req_q.kind == KIND_GET))
    else $error("result raised outside a get");

endmodule
